### rtl/stxfp_pkg.sv
// ----------------------------------------------------------------------------
// stxfp_pkg
// Shared types, constants and helpers for the sync/type/XOR frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stxfp_pkg;

  localparam int MAX_PAYLOAD = 128;
  localparam int STORE_DEPTH = 128;
  localparam int LEN_LIMIT   = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
  localparam int WORD_DEPTH  = STORE_DEPTH / 8;
  localparam int WADDR_W     = $clog2(WORD_DEPTH);

  localparam logic [7:0] SYNC_RESET  = 8'hAB;
  localparam logic [7:0] LEN_LIMIT_B = 8'(LEN_LIMIT);
  localparam logic [7:0] FT_KEYBOARD = 8'd1;
  localparam logic [7:0] FT_MOUSE    = 8'd2;
  localparam logic [7:0] FT_CTRL     = 8'd3;
  localparam logic [7:0] FT_CFG      = 8'd4;

  typedef enum logic [2:0] {
    ST_SYNC    = 3'd0,
    ST_TYPE    = 3'd1,
    ST_LEN     = 3'd2,
    ST_PAYLOAD = 3'd3,
    ST_CSUM    = 3'd4,
    ST_EMIT_RD = 3'd5,
    ST_EMIT_OUT = 3'd6
  } state_t;

  typedef struct packed {
    logic load_type;
    logic load_len;
    logic load_byte;
    logic clr_word;
    logic inc_word;
    logic rd_en;
  } cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic is_config;
    logic fixed_zero;
    logic len_zero;
    logic len_over;
    logic payload_done;
    logic csum_ok;
    logic last_word;
  } sts_t;

  function automatic logic [7:0] fixed_length(input logic [7:0] t);
    logic [7:0] len;
    case (t)
      FT_KEYBOARD: len = 8'd8;
      FT_MOUSE:    len = 8'd6;
      FT_CTRL:     len = 8'd1;
      default:     len = 8'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/stxfp_ram.sv
// ----------------------------------------------------------------------------
// stxfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stxfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/stxfp_ctrl.sv
// ----------------------------------------------------------------------------
// stxfp_ctrl
// Frame parser controller: sync hunt, header, payload, checksum, word emit.
// ----------------------------------------------------------------------------
`default_nettype none

module stxfp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire stxfp_pkg::sts_t sts,
  output stxfp_pkg::cmd_t    cmd
);
  import stxfp_pkg::*;

  state_t state_r, state_nxt;
  logic   acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SYNC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_SYNC: begin
        in_ready = 1'b1;
        if (acc && sts.sync_hit) state_nxt = ST_TYPE;
      end
      ST_TYPE: begin
        in_ready = 1'b1;
        if (acc) begin
          cmd.load_type = 1'b1;
          if (sts.is_config)       state_nxt = ST_LEN;
          else if (sts.fixed_zero) state_nxt = ST_SYNC;
          else                     state_nxt = ST_PAYLOAD;
        end
      end
      ST_LEN: begin
        in_ready = 1'b1;
        if (acc) begin
          cmd.load_len = 1'b1;
          if (sts.len_over)      state_nxt = ST_SYNC;
          else if (sts.len_zero) state_nxt = ST_CSUM;
          else                   state_nxt = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        in_ready = 1'b1;
        if (acc) begin
          cmd.load_byte = 1'b1;
          if (sts.payload_done) state_nxt = ST_CSUM;
        end
      end
      ST_CSUM: begin
        in_ready = 1'b1;
        if (acc) begin
          if (sts.csum_ok) begin
            cmd.clr_word = 1'b1;
            state_nxt    = ST_EMIT_RD;
          end else begin
            state_nxt = ST_SYNC;
          end
        end
      end
      ST_EMIT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last_word) begin
            state_nxt = ST_SYNC;
          end else begin
            cmd.inc_word = 1'b1;
            state_nxt    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_SYNC;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output active together");

  a_rd_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_RD) |=> (state_r == ST_EMIT_OUT))
    else $error("read not followed by output");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && sts.last_word) |=> (state_r == ST_SYNC))
    else $error("last word did not end frame");

endmodule

`default_nettype wire

### rtl/stxfp_dp.sv
// ----------------------------------------------------------------------------
// stxfp_dp
// Datapath: header registers, XOR checksum, word assembly, payload RAM, output.
// ----------------------------------------------------------------------------
`default_nettype none

module stxfp_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [7:0]      cfg_wr_data,
  input  wire logic [7:0]      rx_byte,
  input  wire stxfp_pkg::cmd_t cmd,
  output stxfp_pkg::sts_t      sts,
  output logic [2:0]           frame_type,
  output logic [7:0]           frame_length,
  output logic [stxfp_pkg::WADDR_W-1:0] word_index,
  output logic [63:0]          word_data,
  output logic [3:0]           bytes_valid
);
  import stxfp_pkg::*;

  logic [7:0]         sync_r;
  logic [7:0]         type_r;
  logic [7:0]         xor_r;
  logic [7:0]         exp_r;
  logic [7:0]         rcv_r;
  logic [WADDR_W-1:0] word_r;
  logic [7:0][7:0]    acc_r, acc_nxt;
  logic [8:0]         rcv_inc;
  logic [7:0]         len_m1;
  logic               wr_en;
  logic [7:0][7:0]    rd_word;

  assign rcv_inc = {1'b0, rcv_r} + 9'd1;
  assign len_m1  = exp_r - 8'd1;

  always_comb begin
    acc_nxt             = acc_r;
    acc_nxt[rcv_r[2:0]] = rx_byte;
  end

  assign sts.sync_hit     = (rx_byte == sync_r);
  assign sts.is_config    = (rx_byte == FT_CFG);
  assign sts.fixed_zero   = (fixed_length(rx_byte) == 8'd0);
  assign sts.len_zero     = (rx_byte == 8'd0);
  assign sts.len_over     = (rx_byte > LEN_LIMIT_B);
  assign sts.payload_done = (rcv_inc >= {1'b0, exp_r});
  assign sts.csum_ok      = (rx_byte == xor_r);
  assign sts.last_word    = (exp_r == 8'd0) ? (word_r == '0)
                                            : (word_r == len_m1[WADDR_W+2:3]);

  assign wr_en = cmd.load_byte && ((rcv_r[2:0] == 3'd7) || sts.payload_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
      type_r <= '0;
      xor_r  <= '0;
      exp_r  <= '0;
      rcv_r  <= '0;
      word_r <= '0;
    end else begin
      if (cfg_wr_en) sync_r <= cfg_wr_data;
      if (cmd.load_type) begin
        type_r <= rx_byte;
        xor_r  <= rx_byte;
        rcv_r  <= '0;
        exp_r  <= fixed_length(rx_byte);
      end
      if (cmd.load_len) begin
        exp_r <= rx_byte;
        xor_r <= xor_r ^ rx_byte;
      end
      if (cmd.load_byte) begin
        rcv_r <= rcv_inc[7:0];
        xor_r <= xor_r ^ rx_byte;
      end
      if (cmd.clr_word) word_r <= '0;
      if (cmd.inc_word) word_r <= word_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) acc_r <= acc_nxt;
  end

  stxfp_ram #(
    .WIDTH (64),
    .DEPTH (WORD_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rcv_r[WADDR_W+2:3]),
    .wr_data (acc_nxt),
    .rd_en   (cmd.rd_en),
    .rd_addr (word_r),
    .rd_data (rd_word)
  );

  always_comb begin
    if (!sts.last_word)      bytes_valid = 4'd8;
    else if (exp_r == 8'd0)  bytes_valid = 4'd0;
    else                     bytes_valid = {1'b0, len_m1[2:0]} + 4'd1;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word_data[8*i +: 8] = (4'(i) < bytes_valid) ? rd_word[i] : 8'd0;
    end
  end

  assign frame_type   = type_r[2:0];
  assign frame_length = exp_r;
  assign word_index   = word_r;

  a_rcv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcv_r <= LEN_LIMIT_B)
    else $error("payload count past limit");

  a_bv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_valid <= 4'd8)
    else $error("bytes_valid out of range");

  a_wr_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_byte |=> (rcv_r == $past(rcv_r) + 8'd1))
    else $error("payload count did not advance");

endmodule

`default_nettype wire

### rtl/sync_type_xor_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_type_xor_frame_parser
// Sync/type/length deframer with XOR checksum; emits payload as 64-bit words.
// ----------------------------------------------------------------------------
//  channel  signals                        direction  handshake
//  in       in_rx_byte                     input      in_valid / in_ready
//  out      out_frame_type .. out_last_word output     out_valid / out_ready
//  cfg      cfg_wr_data                    input      cfg_wr_en, no wait
//
//  One received byte per cycle while parsing (in_ready high).
//  A good checksum byte starts emission: each word is a RAM read, then an
//  output, up to 16 words; in_ready is low until the last word is taken.
//  Payload bytes pack into a 64-bit word that is written to a 16x64 RAM.
//  Synchronous active-low reset returns to sync hunt; out_ready stalls hold
//  the current word.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_type_xor_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_frame_type,
  output logic [7:0]       out_frame_length,
  output logic [3:0]       out_word_index,
  output logic [63:0]      out_word_data,
  output logic [3:0]       out_bytes_valid,
  output logic             out_last_word
);
  import stxfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stxfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stxfp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .rx_byte      (in_rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .frame_type   (out_frame_type),
    .frame_length (out_frame_length),
    .word_index   (out_word_index),
    .word_data    (out_word_data),
    .bytes_valid  (out_bytes_valid)
  );

  assign out_last_word = sts.last_word;

endmodule

`default_nettype wire
